>>> rtl/setq_pkg.sv
package setq_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_ADJUST = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  // ins: sorted insert of the request entry (shift toward the tail)
  // del: remove the matching entry (shift toward the head)
  // pop: together with del, remove the head entry instead of the matching one
  typedef struct packed {
    logic ins;
    logic del;
    logic pop;
  } cell_ctl_t;

endpackage

>>> rtl/setq_cell.sv
module setq_cell #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  setq_pkg::cell_ctl_t    ctl,
  input  logic [ID_BITS-1:0]     req_id,
  input  logic [TIME_BITS-1:0]   req_time,
  input  logic [TIME_BITS-1:0]   left_exp,
  input  logic [ID_BITS-1:0]     left_conn,
  input  logic                   left_valid,
  input  logic                   left_le,
  input  logic [TIME_BITS-1:0]   right_exp,
  input  logic [ID_BITS-1:0]     right_conn,
  input  logic                   right_valid,
  input  logic                   prior_in,
  output logic [TIME_BITS-1:0]   exp,
  output logic [ID_BITS-1:0]     conn,
  output logic                   valid,
  output logic                   le,
  output logic                   lt,
  output logic                   prior_out
);

  logic match;
  logic take_right;
  logic take_new;
  logic take_left;

  assign match      = valid && (conn == req_id);
  assign le         = valid && (exp <= req_time);
  assign lt         = valid && (exp < req_time);
  assign prior_out  = prior_in | match;

  assign take_right = ctl.del && prior_out;
  assign take_new   = ctl.ins && !le && left_le;
  assign take_left  = ctl.ins && !le && !left_le;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_right) begin
      valid <= right_valid;
    end else if (take_new) begin
      valid <= 1'b1;
    end else if (take_left) begin
      valid <= left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_right) begin
      exp  <= right_exp;
      conn <= right_conn;
    end else if (take_new) begin
      exp  <= req_time;
      conn <= req_id;
    end else if (take_left) begin
      exp  <= left_exp;
      conn <= left_conn;
    end
  end

endmodule

>>> rtl/sorted_expiry_timer_queue.sv
// Sorted connection timer queue: up to DEPTH timers held in a chain of cells in
// ascending expiry order, equal expiries in arrival order. Every cell compares its
// entry with the broadcast request combinationally and shifts toward the head
// (delete, pop) or the tail (insert). One request is processed at a time: add and
// delete give their result from a check state, adjust deletes in the check state
// and inserts in a second state, and tick gives one expired entry per cycle while
// the output is not stalled, after a lookup state, or a single "nothing expired"
// result. in_ready rises again as the last result enters the output register.
// Output stalls hold the chain. No clearing pass is needed after reset.
module sorted_expiry_timer_queue #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [ID_BITS-1:0]             conn_id,
  input  logic [TIME_BITS-1:0]           time_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [ID_BITS-1:0]             conn_id_out,
  output logic                           last,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_INS   = 2'd2;
  localparam logic [1:0] S_TICK  = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [1:0]           req_cmd;
  logic [ID_BITS-1:0]   req_id;
  logic [TIME_BITS-1:0] req_time;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  setq_pkg::cell_ctl_t  ctl;

  logic [TIME_BITS-1:0] c_exp   [DEPTH];
  logic [ID_BITS-1:0]   c_conn  [DEPTH];
  logic [DEPTH-1:0]     c_valid;
  logic [DEPTH-1:0]     c_le;
  logic [DEPTH-1:0]     c_lt;
  logic [DEPTH-1:0]     c_prior;

  logic                 out_free;
  logic                 found;
  logic                 emit;
  logic [2:0]           e_status;
  logic [ID_BITS-1:0]   e_id;
  logic                 e_last;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [TIME_BITS-1:0] l_exp;
      logic [ID_BITS-1:0]   l_conn;
      logic                 l_valid;
      logic                 l_le;
      logic [TIME_BITS-1:0] r_exp;
      logic [ID_BITS-1:0]   r_conn;
      logic                 r_valid;
      logic                 p_in;

      if (gi == 0) begin : g_head
        assign l_exp   = '0;
        assign l_conn  = '0;
        assign l_valid = 1'b0;
        assign l_le    = 1'b1;
        assign p_in    = ctl.pop;
      end else begin : g_body
        assign l_exp   = c_exp[gi-1];
        assign l_conn  = c_conn[gi-1];
        assign l_valid = c_valid[gi-1];
        assign l_le    = c_le[gi-1];
        assign p_in    = c_prior[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign r_exp   = '0;
        assign r_conn  = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner
        assign r_exp   = c_exp[gi+1];
        assign r_conn  = c_conn[gi+1];
        assign r_valid = c_valid[gi+1];
      end

      setq_cell #(
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .req_id      (req_id),
        .req_time    (req_time),
        .left_exp    (l_exp),
        .left_conn   (l_conn),
        .left_valid  (l_valid),
        .left_le     (l_le),
        .right_exp   (r_exp),
        .right_conn  (r_conn),
        .right_valid (r_valid),
        .prior_in    (p_in),
        .exp         (c_exp[gi]),
        .conn        (c_conn[gi]),
        .valid       (c_valid[gi]),
        .le          (c_le[gi]),
        .lt          (c_lt[gi]),
        .prior_out   (c_prior[gi])
      );
    end
  endgenerate

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign found    = c_prior[DEPTH-1];

  always_comb begin
    state_next = state;
    count_next = count;
    ctl        = '0;
    emit       = 1'b0;
    e_status   = setq_pkg::ST_OK;
    e_id       = req_id;
    e_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (req_cmd == setq_pkg::CMD_TICK) begin
          state_next = S_TICK;
        end else if (out_free) begin
          state_next = S_IDLE;
          unique case (req_cmd)
            setq_pkg::CMD_ADD: begin
              emit = 1'b1;
              if (found) begin
                e_status = setq_pkg::ST_DUPLICATE;
              end else if (count == CW'(DEPTH)) begin
                e_status = setq_pkg::ST_FULL;
              end else begin
                ctl.ins    = 1'b1;
                count_next = count + 1'b1;
              end
            end
            setq_pkg::CMD_DELETE: begin
              emit = 1'b1;
              if (!found) begin
                e_status = setq_pkg::ST_NOT_FOUND;
              end else begin
                ctl.del    = 1'b1;
                count_next = count - 1'b1;
              end
            end
            setq_pkg::CMD_ADJUST: begin
              if (!found) begin
                emit     = 1'b1;
                e_status = setq_pkg::ST_NOT_FOUND;
              end else begin
                ctl.del    = 1'b1;
                count_next = count - 1'b1;
                state_next = S_INS;
              end
            end
            default: begin
              state_next = S_TICK;
            end
          endcase
        end
      end
      S_INS: begin
        if (out_free) begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          emit = 1'b1;
          if (c_lt[0]) begin
            ctl.del    = 1'b1;
            ctl.pop    = 1'b1;
            count_next = count - 1'b1;
            e_status   = setq_pkg::ST_EXPIRED;
            e_id       = c_conn[0];
            e_last     = !c_lt[1];
            if (!c_lt[1]) begin
              state_next = S_IDLE;
            end
          end else begin
            e_status   = setq_pkg::ST_NONE;
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd  <= command;
      req_id   <= conn_id;
      req_time <= time_value;
    end
    if (emit) begin
      status      <= e_status;
      conn_id_out <= e_id;
      last        <= e_last;
      occupancy   <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("timer count above depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == int'(count))
    else $error("valid cells disagree with count");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == setq_pkg::ST_NONE |-> last)
    else $error("nothing-expired result without last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_CHECK)
    else $error("accepted request not in check");
`endif

endmodule

>>> bench/tb_sorted_expiry_timer_queue.sv
module tb_sorted_expiry_timer_queue;

  localparam int DEPTH        = 32;
  localparam int TIME_BITS    = 32;
  localparam int ID_BITS      = 10;
  localparam int OCC_BITS     = $clog2(DEPTH + 1);
  localparam int IDLE_LIMIT   = 400;
  localparam int RANDOM_COUNT = 127;
  localparam int SCRIPT_LEN   = 23;
  localparam int REPLY_SLOTS  = 64;

  typedef struct packed {
    logic [2:0]          status;
    logic [ID_BITS-1:0]  conn;
    logic                last;
    logic [OCC_BITS-1:0] occ;
  } timer_reply_t;

  // typed = 1: single reply with the request id and last set, known up front
  typedef struct packed {
    logic [1:0]           cmd;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] t;
    logic                 typed;
    logic [2:0]           status;
    logic [OCC_BITS-1:0]  occ;
  } script_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           command = setq_pkg::CMD_ADD;
  logic [ID_BITS-1:0]   conn_id = '0;
  logic [TIME_BITS-1:0] time_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           status;
  logic [ID_BITS-1:0]   conn_id_out;
  logic                 last;
  logic [OCC_BITS-1:0]  occupancy;

  sorted_expiry_timer_queue #(
    .DEPTH(DEPTH),
    .TIME_BITS(TIME_BITS),
    .ID_BITS(ID_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .conn_id(conn_id),
    .time_value(time_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .conn_id_out(conn_id_out),
    .last(last),
    .occupancy(occupancy)
  );

  // shadow timer list, sorted by expiry, equal expiries in arrival order
  logic [TIME_BITS-1:0] list_expiry [DEPTH];
  logic [ID_BITS-1:0]   list_conn   [DEPTH];
  int                   list_len = 0;
  // awaited replies, oldest at reply_head
  timer_reply_t         reply_ring [REPLY_SLOTS];
  int                   reply_head = 0;
  int                   reply_count = 0;
  int                   errors = 0;
  int                   idle_cycles = 0;
  int                   burst_left = 0;
  int                   rx_count = 0;

  script_row_t timer_script [SCRIPT_LEN] = '{
    '{setq_pkg::CMD_TICK,   10'd5,    32'd100,       1'b1, setq_pkg::ST_NONE,      6'd0},
    '{setq_pkg::CMD_DELETE, 10'd7,    32'd0,         1'b1, setq_pkg::ST_NOT_FOUND, 6'd0},
    '{setq_pkg::CMD_ADJUST, 10'd7,    32'd5,         1'b1, setq_pkg::ST_NOT_FOUND, 6'd0},
    '{setq_pkg::CMD_ADD,    10'd0,    32'd0,         1'b1, setq_pkg::ST_OK,        6'd1},
    '{setq_pkg::CMD_ADD,    10'd1023, 32'hFFFF_FFFF, 1'b1, setq_pkg::ST_OK,        6'd2},
    '{setq_pkg::CMD_ADD,    10'd0,    32'd50,        1'b1, setq_pkg::ST_DUPLICATE, 6'd2},
    '{setq_pkg::CMD_ADD,    10'd512,  32'd100,       1'b1, setq_pkg::ST_OK,        6'd3},
    '{setq_pkg::CMD_ADD,    10'd300,  32'd100,       1'b1, setq_pkg::ST_OK,        6'd4},
    '{setq_pkg::CMD_ADD,    10'd301,  32'd100,       1'b1, setq_pkg::ST_OK,        6'd5},
    '{setq_pkg::CMD_ADD,    10'd682,  32'd0,         1'b1, setq_pkg::ST_OK,        6'd6},
    '{setq_pkg::CMD_ADJUST, 10'd512,  32'd100,       1'b1, setq_pkg::ST_OK,        6'd6},
    '{setq_pkg::CMD_TICK,   10'd341,  32'd0,         1'b1, setq_pkg::ST_NONE,      6'd6},
    '{setq_pkg::CMD_TICK,   10'd77,   32'd1,         1'b0, setq_pkg::ST_OK,        6'd0},
    '{setq_pkg::CMD_DELETE, 10'd300,  32'd0,         1'b1, setq_pkg::ST_OK,        6'd3},
    '{setq_pkg::CMD_ADJUST, 10'd1023, 32'd7,         1'b1, setq_pkg::ST_OK,        6'd3},
    '{setq_pkg::CMD_TICK,   10'd9,    32'd101,       1'b0, setq_pkg::ST_OK,        6'd0},
    '{setq_pkg::CMD_TICK,   10'd1023, 32'hFFFF_FFFF, 1'b1, setq_pkg::ST_NONE,      6'd0},
    '{setq_pkg::CMD_ADD,    10'd5,    32'hFFFF_FFFF, 1'b1, setq_pkg::ST_OK,        6'd1},
    '{setq_pkg::CMD_TICK,   10'd6,    32'hFFFF_FFFF, 1'b1, setq_pkg::ST_NONE,      6'd1},
    '{setq_pkg::CMD_DELETE, 10'd5,    32'd0,         1'b1, setq_pkg::ST_OK,        6'd0},
    '{setq_pkg::CMD_ADD,    10'd341,  32'h5555_5555, 1'b1, setq_pkg::ST_OK,        6'd1},
    '{setq_pkg::CMD_ADD,    10'd682,  32'hAAAA_AAAA, 1'b1, setq_pkg::ST_OK,        6'd2},
    '{setq_pkg::CMD_TICK,   10'd0,    32'hAAAA_AAAB, 1'b0, setq_pkg::ST_OK,        6'd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reply_put(timer_reply_t r);
    reply_ring[(reply_head + reply_count) % REPLY_SLOTS] = r;
    reply_count++;
  endfunction

  function automatic timer_reply_t reply_take();
    timer_reply_t r;
    r          = reply_ring[reply_head];
    reply_head = (reply_head + 1) % REPLY_SLOTS;
    reply_count--;
    return r;
  endfunction

  function automatic int newest_slot();
    return (reply_head + reply_count - 1) % REPLY_SLOTS;
  endfunction

  function automatic int find_timer(logic [ID_BITS-1:0] id);
    for (int i = 0; i < list_len; i++) begin
      if (list_conn[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_expiry[i] = list_expiry[i+1];
      list_conn[i]   = list_conn[i+1];
    end
    list_len--;
  endfunction

  function automatic void place_timer(logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] t);
    int pos;
    pos = 0;
    while (pos < list_len && list_expiry[pos] <= t) pos++;
    for (int i = list_len; i > pos; i--) begin
      list_expiry[i] = list_expiry[i-1];
      list_conn[i]   = list_conn[i-1];
    end
    list_expiry[pos] = t;
    list_conn[pos]   = id;
    list_len++;
  endfunction

  function automatic void await_reply(logic [2:0] st, logic [ID_BITS-1:0] id, logic lst);
    timer_reply_t r;
    r.status = st;
    r.conn   = id;
    r.last   = lst;
    r.occ    = OCC_BITS'(list_len);
    reply_put(r);
  endfunction

  function automatic void advance_timer_list(logic [1:0] cmd, logic [ID_BITS-1:0] id,
                                             logic [TIME_BITS-1:0] t);
    int pos;
    int popped;
    logic [ID_BITS-1:0] gone;
    popped = 0;
    case (cmd)
      setq_pkg::CMD_ADD: begin
        if (find_timer(id) >= 0) await_reply(setq_pkg::ST_DUPLICATE, id, 1'b1);
        else if (list_len >= DEPTH) await_reply(setq_pkg::ST_FULL, id, 1'b1);
        else begin
          place_timer(id, t);
          await_reply(setq_pkg::ST_OK, id, 1'b1);
        end
      end
      setq_pkg::CMD_DELETE, setq_pkg::CMD_ADJUST: begin
        pos = find_timer(id);
        if (pos < 0) await_reply(setq_pkg::ST_NOT_FOUND, id, 1'b1);
        else begin
          drop_timer(pos);
          if (cmd == setq_pkg::CMD_ADJUST) place_timer(id, t);
          await_reply(setq_pkg::ST_OK, id, 1'b1);
        end
      end
      setq_pkg::CMD_TICK: begin
        while (list_len > 0 && popped < DEPTH && list_expiry[0] < t) begin
          gone = list_conn[0];
          drop_timer(0);
          await_reply(setq_pkg::ST_EXPIRED, gone, 1'b0);
          popped++;
        end
        if (popped == 0) await_reply(setq_pkg::ST_NONE, id, 1'b1);
        else reply_ring[newest_slot()].last = 1'b1;
      end
    endcase
  endfunction

  function automatic logic [ID_BITS-1:0] fresh_id();
    logic [ID_BITS-1:0] id;
    id = ID_BITS'($urandom);
    while (find_timer(id) >= 0) id = ID_BITS'($urandom);
    return id;
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id();
    if (list_len > 0 && $urandom_range(0, 9) < 7)
      return list_conn[$urandom_range(0, list_len - 1)];
    return ID_BITS'($urandom);
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_expiry(logic [TIME_BITS-1:0] now);
    case ($urandom_range(0, 9))
      0: return TIME_BITS'($urandom);
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return now + TIME_BITS'($urandom_range(0, 48));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] cmd, logic [ID_BITS-1:0] id,
                              logic [TIME_BITS-1:0] t);
    int gap;
    bit taken;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    conn_id    <= id;
    time_value <= t;
    do begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end while (!taken);
    advance_timer_list(cmd, id, t);
  endtask

  task automatic hold_until_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (reply_count != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    rx_count <= rx_count + 1;
    case ((rx_count / 89) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 6);
      default: out_ready <= ((rx_count % 7) < 4);
    endcase
  end

  always @(posedge clk) begin : check_replies
    timer_reply_t seen;
    timer_reply_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{status, conn_id_out, last, occupancy};
      if (reply_count == 0) begin
        errors++;
        $display("%0t: unexpected reply: status %0d id %0d last %0b occupancy %0d",
                 $time, seen.status, seen.conn, seen.last, seen.occ);
      end else begin
        want = reply_take();
        if (seen !== want) begin
          errors++;
          $display("%0t: expected status %0d id %0d last %0b occupancy %0d, got %0d %0d %0b %0d",
                   $time, want.status, want.conn, want.last, want.occ,
                   seen.status, seen.conn, seen.last, seen.occ);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    int                   made;
    int                   full_hits;
    int                   mixed_left;
    int                   pick;
    bit                   filling;
    bit                   settle;
    logic [1:0]           cmd;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] now;
    timer_reply_t         typed_reply;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_request(timer_script[i].cmd, timer_script[i].id, timer_script[i].t);
      if (timer_script[i].typed) begin
        typed_reply.status = timer_script[i].status;
        typed_reply.conn   = timer_script[i].id;
        typed_reply.last   = 1'b1;
        typed_reply.occ    = timer_script[i].occ;
        reply_ring[newest_slot()] = typed_reply;
      end
    end

    made       = 0;
    full_hits  = 0;
    mixed_left = 0;
    filling    = 1'b1;
    now        = TIME_BITS'($urandom_range(0, 1000));
    while (made < RANDOM_COUNT) begin
      settle = 1'b0;
      if (filling && list_len < DEPTH) begin
        cmd = setq_pkg::CMD_ADD;
        id  = ($urandom_range(0, 9) == 0 && list_len > 0) ? pick_id() : fresh_id();
        t   = pick_expiry(now);
      end else if (filling) begin
        // list full: duplicates still win over full
        cmd = setq_pkg::CMD_ADD;
        id  = $urandom_range(0, 1) ? pick_id() : fresh_id();
        t   = pick_expiry(now);
        full_hits++;
        if (full_hits >= 3) begin
          filling    = 1'b0;
          full_hits  = 0;
          mixed_left = $urandom_range(40, 60);
          settle     = 1'b1;
        end
      end else begin
        pick = $urandom_range(0, 9);
        cmd  = (pick < 3) ? setq_pkg::CMD_ADD :
               (pick < 5) ? setq_pkg::CMD_DELETE :
               (pick < 7) ? setq_pkg::CMD_ADJUST : setq_pkg::CMD_TICK;
        id   = pick_id();
        if (cmd == setq_pkg::CMD_TICK) begin
          now = now + TIME_BITS'($urandom_range(0, 24));
          t   = ($urandom_range(0, 9) == 0) ? pick_expiry(now) : now;
        end else t = pick_expiry(now);
        mixed_left--;
        if (mixed_left == 0) begin
          filling = 1'b1;
          if ($urandom_range(0, 1)) now = TIME_BITS'($urandom);
        end
      end
      send_request(cmd, id, t);
      made++;
      if (settle) hold_until_drained();
    end

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
